### sv/vrbs_pkg.sv
// shared types, codes and defaults for the variable-length record byte stack
package vrbs_pkg;

   // field widths
   localparam int OP_W     = 3;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 7;
   localparam int STATUS_W = 2;

   // parameter defaults
   localparam int DEF_STACK_BYTES  = 1024;
   localparam int DEF_HEADER_BYTES = 4;
   localparam int DEF_MAX_RECORD   = 64;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
   localparam logic [OP_W-1:0] OP_POP   = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
   localparam logic [OP_W-1:0] OP_FIT   = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // saturation point of the received byte count
   localparam logic [LEN_W-1:0] TAKEN_SAT = '1;

   // byte store port strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctl_type;

endpackage

### sv/vrbs_ram.sv
// byte store: one write port, one read port with registered read data
module vrbs_ram #(
   parameter int DEPTH = vrbs_pkg::DEF_STACK_BYTES
) (
   input  logic                        clock,
   input  vrbs_pkg::ram_ctl_type       ctl,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [vrbs_pkg::BYTE_W-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [vrbs_pkg::BYTE_W-1:0] rd_data
);

   logic [vrbs_pkg::BYTE_W-1:0] mem_ff [DEPTH];
   logic [vrbs_pkg::BYTE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/variable_record_byte_stack.sv
// top level of the variable-length record byte stack
// push: one beat per cycle while not stalled, its result registered the cycle after; the last
//    beat of a fitting record adds one header write per header byte on the single write port
// pop/peek: HEADER_BYTES header reads, S_HWAIT, S_CALC, then one byte per cycle unless stalled
// clear, fit check and other ops: result registered the cycle after
// reset: a clearing pass over all STACK_BYTES addresses zeroes the byte store, input stalled meanwhile
module variable_record_byte_stack #(
   parameter int STACK_BYTES  = vrbs_pkg::DEF_STACK_BYTES,
   parameter int HEADER_BYTES = vrbs_pkg::DEF_HEADER_BYTES,
   parameter int MAX_RECORD   = vrbs_pkg::DEF_MAX_RECORD
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [vrbs_pkg::OP_W-1:0]     req_op,
   input  logic [vrbs_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic [vrbs_pkg::LEN_W-1:0]    req_record_length,
   input  logic                          req_last,
   input  logic [vrbs_pkg::LEN_W-1:0]    req_max_bytes,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [vrbs_pkg::STATUS_W-1:0] rsp_status,
   output logic [vrbs_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_last_result,
   output logic                          rsp_stack_empty
);

   localparam int LEN_W  = vrbs_pkg::LEN_W;
   localparam int BYTE_W = vrbs_pkg::BYTE_W;
   localparam int ST_W   = vrbs_pkg::STATUS_W;
   localparam int ADDR_W = $clog2(STACK_BYTES);
   localparam int TOP_W  = ADDR_W + 1;
   localparam int EXT_W  = TOP_W + 7;
   localparam int HDR_W  = 8 * HEADER_BYTES;
   localparam int NT_W   = ((EXT_W > HDR_W) ? EXT_W : HDR_W) + 1;
   localparam int HCNT_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

   localparam logic [TOP_W-1:0]  TOP_EMPTY = TOP_W'(STACK_BYTES);
   localparam logic [EXT_W-1:0]  STACK_EXT = EXT_W'(STACK_BYTES);
   localparam logic [EXT_W-1:0]  HDR_EXT   = EXT_W'(HEADER_BYTES);
   localparam logic [NT_W-1:0]   STACK_NT  = NT_W'(STACK_BYTES);
   localparam logic [NT_W-1:0]   HDR_NT    = NT_W'(HEADER_BYTES);
   localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_RECORD);
   localparam logic [HCNT_W-1:0] HCNT_LAST = HCNT_W'(HEADER_BYTES - 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STACK_BYTES - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WHDR,
      S_RHDR,
      S_HWAIT,
      S_CALC,
      S_DATA
   } state_type;

   // control registers
   state_type         state_ff, state_in;
   logic [TOP_W-1:0]  top_ff, top_in;
   logic              open_ff, open_in;
   logic              rej_ff, rej_in;
   logic [LEN_W-1:0]  taken_ff, taken_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [HCNT_W-1:0] hcnt_ff, hcnt_in;
   logic [LEN_W-1:0]  hdr_len_ff, hdr_len_in;
   logic [ADDR_W-1:0] hdr_base_ff, hdr_base_in;
   logic              pop_ff, pop_in;
   logic [LEN_W-1:0]  maxb_ff, maxb_in;
   logic [HDR_W-1:0]  stored_ff, stored_in;
   logic              rd_oob_ff, rd_oob_in;
   logic [HCNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [LEN_W-1:0]  cnt_n_ff, cnt_n_in;
   logic [LEN_W-1:0]  issue_ff, issue_in;
   logic [LEN_W-1:0]  recv_ff, recv_in;
   logic [EXT_W-1:0]  data_at_ff, data_at_in;

   // result register
   logic [ST_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_bvalid_ff, rsp_bvalid_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_empty_ff, rsp_empty_in;

   // byte store port
   vrbs_pkg::ram_ctl_type ram_ctl;
   logic [ADDR_W-1:0]     wr_addr;
   logic [BYTE_W-1:0]     wr_data;
   logic [ADDR_W-1:0]     rd_addr;
   logic [BYTE_W-1:0]     rd_data;

   // combinational helpers
   logic              accept;
   logic              out_free;
   logic              fits;
   logic              cur_rej;
   logic [LEN_W-1:0]  cur_taken;
   logic              push_rej;
   logic [LEN_W-1:0]  taken_next;
   logic [EXT_W-1:0]  push_addr;
   logic [EXT_W-1:0]  push_base;
   logic [TOP_W-1:0]  push_top;
   logic [HDR_W-1:0]  hdr_shift;
   logic [BYTE_W-1:0] rd_byte;
   logic [EXT_W-1:0]  hrd_addr;
   logic [EXT_W-1:0]  drd_addr;
   logic [LEN_W-1:0]  n_cap;
   logic [LEN_W-1:0]  n_take;
   logic [NT_W-1:0]   pop_top;
   logic              do_load;
   logic              do_issue;

   vrbs_ram #(
      .DEPTH (STACK_BYTES)
   ) u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   // fit rule against the current top
   assign fits = (req_record_length <= MAX_LEN) &&
                 (EXT_W'(top_ff) >= EXT_W'(req_record_length) + HDR_EXT);

   // push bookkeeping, a new record starts when none is open
   assign cur_rej    = open_ff ? rej_ff : 1'b0;
   assign cur_taken  = open_ff ? taken_ff : '0;
   assign push_rej   = cur_rej || !fits;
   assign taken_next = (cur_taken != vrbs_pkg::TAKEN_SAT) ? cur_taken + LEN_W'(1) : cur_taken;
   assign push_addr  = EXT_W'(top_ff) - EXT_W'(req_record_length) + EXT_W'(cur_taken);
   assign push_base  = EXT_W'(top_ff) - EXT_W'(req_record_length) - HDR_EXT;
   assign push_top   = push_base[TOP_W-1:0];

   // header byte for the write sequencer
   assign hdr_shift = HDR_W'(hdr_len_ff) >> {hcnt_ff, 3'b000};

   // read data, zero beyond the store
   assign rd_byte = rd_oob_ff ? '0 : rd_data;

   // read addresses
   assign hrd_addr = EXT_W'(top_ff) + EXT_W'(hcnt_ff);
   assign drd_addr = data_at_ff + EXT_W'(issue_ff);

   // bytes to emit and the top after a pop
   assign n_cap   = (HDR_W'(maxb_ff) > stored_ff) ? stored_ff[LEN_W-1:0] : maxb_ff;
   assign n_take  = (n_cap > MAX_LEN) ? MAX_LEN : n_cap;
   assign pop_top = NT_W'(top_ff) + HDR_NT + NT_W'(stored_ff);

   // data streaming handshake with the result register
   assign do_load  = rd_pend_ff && out_free;
   assign do_issue = (issue_ff < cnt_n_ff) && (!rd_pend_ff || do_load);

   // next state
   always_comb begin
      state_in    = state_ff;
      top_in      = top_ff;
      open_in     = open_ff;
      rej_in      = rej_ff;
      taken_in    = taken_ff;
      clr_addr_in = clr_addr_ff;
      rd_pend_in  = 1'b0;
      hcnt_in     = hcnt_ff;
      hdr_len_in  = hdr_len_ff;
      hdr_base_in = hdr_base_ff;
      pop_in      = pop_ff;
      maxb_in     = maxb_ff;
      stored_in   = stored_ff;
      rd_oob_in   = rd_oob_ff;
      rd_idx_in   = rd_idx_ff;
      cnt_n_in    = cnt_n_ff;
      issue_in    = issue_ff;
      recv_in     = recv_ff;
      data_at_in  = data_at_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;

      ram_ctl = '0;
      wr_addr = clr_addr_ff;
      wr_data = '0;
      rd_addr = hrd_addr[ADDR_W-1:0];

      // header bytes come back in the cycle after their read
      if ((state_ff == S_RHDR || state_ff == S_HWAIT) && rd_pend_ff) begin
         stored_in = stored_ff | (HDR_W'(rd_byte) << {rd_idx_ff, 3'b000});
      end

      unique case (state_ff)
         // zero the store after reset
         S_CLEAR: begin
            ram_ctl.wr_en = 1'b1;
            clr_addr_in   = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_LAST) begin
               state_in = S_IDLE;
            end
         end

         // take a beat and answer single-result ops at once
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = vrbs_pkg::ST_OK;
               rsp_byte_in   = '0;
               rsp_bvalid_in = 1'b0;
               rsp_last_in   = 1'b1;
               rsp_empty_in  = (top_ff >= TOP_EMPTY);
               unique case (req_op)
                  vrbs_pkg::OP_PUSH: begin
                     rsp_status_in = push_rej ? vrbs_pkg::ST_FULL : vrbs_pkg::ST_OK;
                     if (!push_rej && (cur_taken < req_record_length)) begin
                        ram_ctl.wr_en = 1'b1;
                        wr_addr       = push_addr[ADDR_W-1:0];
                        wr_data       = req_data_byte;
                     end
                     if (req_last) begin
                        open_in  = 1'b0;
                        rej_in   = 1'b0;
                        taken_in = '0;
                        if (!push_rej) begin
                           top_in       = push_top;
                           rsp_empty_in = (push_top >= TOP_EMPTY);
                           hdr_len_in   = req_record_length;
                           hdr_base_in  = push_base[ADDR_W-1:0];
                           hcnt_in      = '0;
                           state_in     = S_WHDR;
                        end
                     end else begin
                        open_in  = 1'b1;
                        rej_in   = push_rej;
                        taken_in = taken_next;
                     end
                  end
                  vrbs_pkg::OP_POP, vrbs_pkg::OP_PEEK: begin
                     open_in  = 1'b0;
                     rej_in   = 1'b0;
                     taken_in = '0;
                     if (top_ff >= TOP_EMPTY) begin
                        rsp_status_in = vrbs_pkg::ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        pop_in       = (req_op == vrbs_pkg::OP_POP);
                        maxb_in      = req_max_bytes;
                        stored_in    = '0;
                        hcnt_in      = '0;
                        state_in     = S_RHDR;
                     end
                  end
                  vrbs_pkg::OP_CLEAR: begin
                     top_in       = TOP_EMPTY;
                     open_in      = 1'b0;
                     rej_in       = 1'b0;
                     taken_in     = '0;
                     rsp_empty_in = 1'b1;
                  end
                  vrbs_pkg::OP_FIT: begin
                     rsp_status_in = fits ? vrbs_pkg::ST_OK : vrbs_pkg::ST_FULL;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // length header, low byte first, below the data
         S_WHDR: begin
            ram_ctl.wr_en = 1'b1;
            wr_addr       = hdr_base_ff + ADDR_W'(hcnt_ff);
            wr_data       = hdr_shift[BYTE_W-1:0];
            hcnt_in       = hcnt_ff + HCNT_W'(1);
            if (hcnt_ff == HCNT_LAST) begin
               state_in = S_IDLE;
            end
         end

         // read the header of the top record
         S_RHDR: begin
            ram_ctl.rd_en = (hrd_addr < STACK_EXT);
            rd_addr       = hrd_addr[ADDR_W-1:0];
            rd_pend_in    = 1'b1;
            rd_oob_in     = (hrd_addr >= STACK_EXT);
            rd_idx_in     = hcnt_ff;
            hcnt_in       = hcnt_ff + HCNT_W'(1);
            if (hcnt_ff == HCNT_LAST) begin
               state_in = S_HWAIT;
            end
         end

         // last header byte lands
         S_HWAIT: begin
            state_in = S_CALC;
         end

         // byte count, data address and the freed top
         S_CALC: begin
            cnt_n_in   = n_take;
            issue_in   = '0;
            recv_in    = '0;
            data_at_in = EXT_W'(top_ff) + HDR_EXT;
            if (pop_ff) begin
               top_in = (pop_top >= STACK_NT) ? TOP_EMPTY : pop_top[TOP_W-1:0];
            end
            state_in = S_DATA;
         end

         // stream record bytes, one read in flight ahead of the result register
         S_DATA: begin
            if (cnt_n_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = vrbs_pkg::ST_OK;
                  rsp_byte_in   = '0;
                  rsp_bvalid_in = 1'b0;
                  rsp_last_in   = 1'b1;
                  rsp_empty_in  = (top_ff >= TOP_EMPTY);
                  state_in      = S_IDLE;
               end
            end else begin
               rd_addr    = drd_addr[ADDR_W-1:0];
               rd_pend_in = do_issue || (rd_pend_ff && !do_load);
               if (do_issue) begin
                  ram_ctl.rd_en = (drd_addr < STACK_EXT);
                  rd_oob_in     = (drd_addr >= STACK_EXT);
                  issue_in      = issue_ff + LEN_W'(1);
               end
               if (do_load) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = vrbs_pkg::ST_OK;
                  rsp_byte_in   = rd_byte;
                  rsp_bvalid_in = 1'b1;
                  rsp_last_in   = (recv_ff + LEN_W'(1) == cnt_n_ff);
                  rsp_empty_in  = (top_ff >= TOP_EMPTY);
                  recv_in       = recv_ff + LEN_W'(1);
                  if (recv_ff + LEN_W'(1) == cnt_n_ff) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         top_ff       <= TOP_EMPTY;
         open_ff      <= 1'b0;
         rej_ff       <= 1'b0;
         taken_ff     <= '0;
         clr_addr_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         open_ff      <= open_in;
         rej_ff       <= rej_in;
         taken_ff     <= taken_in;
         clr_addr_ff  <= clr_addr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hcnt_ff       <= hcnt_in;
      hdr_len_ff    <= hdr_len_in;
      hdr_base_ff   <= hdr_base_in;
      pop_ff        <= pop_in;
      maxb_ff       <= maxb_in;
      stored_ff     <= stored_in;
      rd_oob_ff     <= rd_oob_in;
      rd_idx_ff     <= rd_idx_in;
      cnt_n_ff      <= cnt_n_in;
      issue_ff      <= issue_in;
      recv_ff       <= recv_in;
      data_at_ff    <= data_at_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_byte_valid  = rsp_bvalid_ff;
   assign rsp_last_result = rsp_last_ff;
   assign rsp_stack_empty = rsp_empty_ff;

endmodule

### sv/vrbs_checker.sv
// port-level checks for the record byte stack, bound to the top level
module vrbs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [vrbs_pkg::STATUS_W-1:0] rsp_status,
   input logic [vrbs_pkg::BYTE_W-1:0]   rsp_out_byte,
   input logic                          rsp_byte_valid,
   input logic                          rsp_last_result,
   input logic                          rsp_stack_empty
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_out_byte) && $stable(rsp_byte_valid) &&
         $stable(rsp_last_result) && $stable(rsp_stack_empty))
      else $error("result beat changed while stalled");

   // an empty answer is a lone beat on an empty stack
   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == vrbs_pkg::ST_EMPTY |->
         rsp_stack_empty && rsp_last_result && !rsp_byte_valid)
      else $error("empty status with stored records or data");

   // record bytes only come with an ok status
   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> rsp_status == vrbs_pkg::ST_OK)
      else $error("record byte with a failing status");

   // a beat without a byte always closes its item
   a_nobyte_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last_result)
      else $error("non-byte beat not marked last");

   // nothing comes out straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind variable_record_byte_stack vrbs_checker u_vrbs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_byte_valid  (rsp_byte_valid),
   .rsp_last_result (rsp_last_result),
   .rsp_stack_empty (rsp_stack_empty)
);

### tb/sv/variable_record_byte_stack_tb.sv
// self-checking testbench for the variable-length record byte stack
`timescale 1ns / 1ps

module variable_record_byte_stack_tb;
   import vrbs_pkg::*;

   localparam int STACK_BYTES   = DEF_STACK_BYTES;
   localparam int HDR_BYTES     = DEF_HEADER_BYTES;
   localparam int MAX_REC       = DEF_MAX_RECORD;
   localparam int RESET_CYCLES  = 4;
   localparam int SETTLE_CYCLES = HDR_BYTES + 16;
   localparam int RANDOM_ITEMS  = 320;
   localparam int IDLE_PERCENT  = 18;
   localparam int LEN_MAX       = 127;

   // op codes the block treats as no-ops
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   out_byte;
      logic                byte_valid;
      logic                last_result;
      logic                stack_empty;
   } stack_rsp_t;

   logic                clock;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_op            = OP_CLEAR;
   logic [BYTE_W-1:0]   req_data_byte     = '0;
   logic [LEN_W-1:0]    req_record_length = '0;
   logic                req_last          = 1'b0;
   logic [LEN_W-1:0]    req_max_bytes     = '0;
   logic                rsp_valid;
   logic                rsp_stall         = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_byte_valid;
   logic                rsp_last_result;
   logic                rsp_stack_empty;

   // expected response beats, oldest first
   stack_rsp_t awaited_beats[$];
   stack_rsp_t head_beat;
   int         fail_count = 0;
   bit         gaps_on    = 1'b1;
   bit         stall_on   = 1'b1;

   // predicted stack contents
   logic [BYTE_W-1:0] store_image[STACK_BYTES];
   int unsigned       stk_top;
   bit                rec_open;
   bit                rec_refused;
   int unsigned       rec_taken;

   variable_record_byte_stack dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_data_byte     (req_data_byte),
      .req_record_length (req_record_length),
      .req_last          (req_last),
      .req_max_bytes     (req_max_bytes),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last_result   (rsp_last_result),
      .rsp_stack_empty   (rsp_stack_empty)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // random back-pressure on the response side
   always @(posedge clock) begin
      rsp_stall <= stall_on && ($urandom_range(99) < IDLE_PERCENT);
   end

   // predicted state helpers
   function automatic bit record_fits(int unsigned len);
      return len <= MAX_REC && stk_top >= len + HDR_BYTES;
   endfunction

   function automatic logic [BYTE_W-1:0] store_get(int unsigned addr);
      return (addr < STACK_BYTES) ? store_image[addr] : '0;
   endfunction

   function automatic void store_put(int unsigned addr, logic [BYTE_W-1:0] val);
      if (addr < STACK_BYTES) store_image[addr] = val;
   endfunction

   function automatic void close_record();
      rec_open    = 1'b0;
      rec_refused = 1'b0;
      rec_taken   = 0;
   endfunction

   function automatic void await_beat(logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] ob,
                                      logic bv, logic lr);
      stack_rsp_t b;
      b.status      = st;
      b.out_byte    = ob;
      b.byte_valid  = bv;
      b.last_result = lr;
      b.stack_empty = (stk_top >= STACK_BYTES);
      awaited_beats.push_back(b);
   endfunction

   function automatic void clear_stack_image();
      foreach (store_image[i]) store_image[i] = '0;
      stk_top = STACK_BYTES;
      close_record();
   endfunction

   // advance the predicted stack by one accepted request and queue its responses
   function automatic void step_stack_image(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                            logic [LEN_W-1:0] len, logic fin,
                                            logic [LEN_W-1:0] maxb);
      logic [STATUS_W-1:0] st;
      longint unsigned     stored;
      longint unsigned     new_top;
      int unsigned         base;
      int unsigned         emit;
      logic [BYTE_W-1:0]   read_out[$];
      st = ST_OK;
      case (op)
         OP_PUSH: begin
            if (!rec_open) begin
               rec_open    = 1'b1;
               rec_refused = 1'b0;
               rec_taken   = 0;
            end
            if (!rec_refused && !record_fits(len)) rec_refused = 1'b1;
            if (rec_refused) begin
               st = ST_FULL;
            end else begin
               if (rec_taken < len) store_put(stk_top - len + rec_taken, data);
               if (fin) begin
                  base = stk_top - len - HDR_BYTES;
                  for (int i = 0; i < HDR_BYTES; i++)
                     store_put(base + i, BYTE_W'(int'(len) >> (8 * i)));
                  stk_top = base;
               end
            end
            if (rec_taken < LEN_MAX) rec_taken++;
            if (fin) close_record();
            await_beat(st, '0, 1'b0, 1'b1);
         end
         OP_POP, OP_PEEK: begin
            close_record();
            if (stk_top >= STACK_BYTES) begin
               await_beat(ST_EMPTY, '0, 1'b0, 1'b1);
            end else begin
               stored = 0;
               for (int i = 0; i < HDR_BYTES; i++)
                  stored |= longint'(store_get(stk_top + i)) << (8 * i);
               emit = maxb;
               if (emit > stored) emit = stored;
               if (emit > MAX_REC) emit = MAX_REC;
               for (int i = 0; i < emit; i++)
                  read_out.push_back(store_get(stk_top + HDR_BYTES + i));
               // pop frees header plus stored length, saturating at empty
               if (op == OP_POP) begin
                  new_top = stk_top + HDR_BYTES + stored;
                  stk_top = (new_top >= STACK_BYTES) ? STACK_BYTES : new_top;
               end
               if (emit == 0) begin
                  await_beat(ST_OK, '0, 1'b0, 1'b1);
               end else begin
                  for (int i = 0; i < emit; i++)
                     await_beat(ST_OK, read_out[i], 1'b1, (i + 1 == emit));
               end
            end
         end
         OP_CLEAR: begin
            stk_top = STACK_BYTES;
            close_record();
            await_beat(ST_OK, '0, 1'b0, 1'b1);
         end
         OP_FIT: begin
            await_beat(record_fits(len) ? ST_OK : ST_FULL, '0, 1'b0, 1'b1);
         end
         default: begin
            await_beat(ST_OK, '0, 1'b0, 1'b1);
         end
      endcase
   endfunction

   // field compare
   task automatic compare_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_beats.size() == 0) begin
            $error("response beat with none awaited: status %0d byte %0d",
                   rsp_status, rsp_out_byte);
            fail_count++;
         end else begin
            head_beat = awaited_beats.pop_front();
            compare_field("status", head_beat.status, rsp_status);
            compare_field("out_byte", head_beat.out_byte, rsp_out_byte);
            compare_field("byte_valid", head_beat.byte_valid, rsp_byte_valid);
            compare_field("last_result", head_beat.last_result, rsp_last_result);
            compare_field("stack_empty", head_beat.stack_empty, rsp_stack_empty);
         end
      end
   end

   // drive one request beat and wait for it to be taken
   task automatic send_beat(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                            logic [LEN_W-1:0] len, logic fin, logic [LEN_W-1:0] maxb);
      while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_data_byte     <= data;
      req_record_length <= len;
      req_last          <= fin;
      req_max_bytes     <= maxb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      step_stack_image(op, data, len, fin, maxb);
   endtask

   // push one record as a run of beats, optionally left open
   task automatic send_record(int len, int beats, bit closed);
      for (int k = 0; k < beats; k++)
         send_beat(OP_PUSH, $urandom_range(255), len, closed && (k == beats - 1),
                   $urandom_range(LEN_MAX));
   endtask

   task automatic send_read(logic [OP_W-1:0] op, int maxb);
      send_beat(op, $urandom_range(255), $urandom_range(LEN_MAX), $urandom_range(1), maxb);
   endtask

   task automatic send_fit(int len);
      send_beat(OP_FIT, $urandom_range(255), len, $urandom_range(1), $urandom_range(LEN_MAX));
   endtask

   // hold the request side until every awaited beat has come back
   task automatic wait_all_answered();
      req_valid <= 1'b0;
      while (awaited_beats.size() != 0) @(posedge clock);
   endtask

   // reads and clear on an empty stack
   task automatic test_empty_stack();
      send_read(OP_POP, MAX_REC);
      send_read(OP_PEEK, LEN_MAX);
      send_read(OP_CLEAR, 0);
      send_read(OP_POP, 0);
   endtask

   // fit rule at the length extremes
   task automatic test_fit_rule();
      send_fit(0);
      send_fit(MAX_REC);
      send_fit(MAX_REC + 1);
      send_fit(LEN_MAX);
   endtask

   // exact, surplus, missing and zero-length records, read back
   task automatic test_record_cases();
      send_beat(OP_PUSH, 8'h00, 3, 1'b0, 0);
      send_beat(OP_PUSH, 8'hFF, 3, 1'b0, LEN_MAX);
      send_beat(OP_PUSH, 8'hA5, 3, 1'b1, 0);
      send_read(OP_PEEK, MAX_REC);
      send_read(OP_PEEK, 0);
      send_read(OP_PEEK, 2);
      // zero-length record with a surplus byte
      send_beat(OP_PUSH, 8'h5A, 0, 1'b1, 0);
      send_read(OP_POP, LEN_MAX);
      send_record(2, 4, 1'b1);
      // only one beat of five: the rest keep old contents
      send_record(5, 1, 1'b1);
      send_read(OP_POP, MAX_REC);
      send_read(OP_POP, MAX_REC);
   endtask

   // abandoned records, length change mid-record, refused record, spare ops
   task automatic test_abandon_and_noise();
      send_record(6, 1, 1'b0);
      send_read(OP_POP, MAX_REC);
      send_record(4, 1, 1'b0);
      send_fit(10);
      send_beat(OP_SPARE_LO, 8'hC3, 0, 1'b0, 0);
      send_record(2, 1, 1'b1);
      send_read(OP_PEEK, MAX_REC);
      send_record(LEN_MAX, 2, 1'b1);
      send_beat(OP_SPARE_HI, 8'h3C, LEN_MAX, 1'b1, LEN_MAX);
      send_read(OP_CLEAR, 0);
   endtask

   // fill the store with single-beat records until the space check fails, then drain it
   task automatic test_full_stack();
      int records;
      records = STACK_BYTES / (MAX_REC + HDR_BYTES) + 1;
      send_read(OP_CLEAR, 0);
      for (int r = 0; r < records; r++) send_record(MAX_REC, 1, 1'b1);
      send_fit(0);
      send_record(0, 1, 1'b1);
      send_fit(0);
      send_record(1, 1, 1'b1);
      for (int r = 0; r <= records + 1; r++) send_read(OP_POP, MAX_REC);
   endtask

   // mostly well-formed records with random content, reads, fit checks and noise
   task automatic test_random_traffic();
      int  done_items;
      int  pick;
      int  roll;
      int  len;
      int  beats;
      bit  paused;
      done_items = 0;
      paused     = 1'b0;
      while (done_items < RANDOM_ITEMS) begin
         // long stretch with no idling on either side
         gaps_on  = !(done_items >= 120 && done_items < 200);
         stall_on = gaps_on;
         if (!paused && done_items >= 240) begin
            wait_all_answered();
            paused = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 50) begin
            roll = $urandom_range(99);
            if (roll < 70) len = $urandom_range(16);
            else if (roll < 92) len = $urandom_range(MAX_REC, 17);
            else len = $urandom_range(LEN_MAX, MAX_REC + 1);
            beats = len;
            roll  = $urandom_range(99);
            if (roll < 15) beats = len + $urandom_range(3, 1);
            else if (roll < 30 && len > 1) beats = $urandom_range(len - 1, 1);
            if (beats == 0) beats = 1;
            // first beat carries a different length
            if (roll >= 94) begin
               send_beat(OP_PUSH, $urandom_range(255), $urandom_range(MAX_REC), 1'b0,
                         $urandom_range(LEN_MAX));
               done_items++;
            end
            send_record(len, beats, $urandom_range(99) >= 6);
            done_items += beats;
         end else begin
            if (pick < 70) send_read(OP_POP, $urandom_range(99) < 85 ?
                                     $urandom_range(MAX_REC) : $urandom_range(LEN_MAX));
            else if (pick < 82) send_read(OP_PEEK, $urandom_range(LEN_MAX));
            else if (pick < 89) send_fit($urandom_range(LEN_MAX));
            else if (pick < 92) send_read(OP_CLEAR, $urandom_range(LEN_MAX));
            else if (pick < 96) send_beat($urandom_range(OP_SPARE_HI, OP_SPARE_LO),
                                          $urandom_range(255), $urandom_range(LEN_MAX),
                                          $urandom_range(1), $urandom_range(LEN_MAX));
            else send_beat(OP_PUSH, $urandom_range(255), $urandom_range(LEN_MAX),
                           $urandom_range(1), $urandom_range(LEN_MAX));
            done_items++;
         end
      end
      gaps_on  = 1'b1;
      stall_on = 1'b1;
   endtask

   // test sequence
   initial begin
      clear_stack_image();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_empty_stack();
      test_fit_rule();
      test_record_cases();
      test_abandon_and_noise();
      wait_all_answered();
      test_full_stack();
      test_random_traffic();
      wait_all_answered();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && awaited_beats.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
